>>> hw/rtl/chunked_message_deframer_assert.svh
// ----------------------------------------------------------------------------
// chunked message deframer assertion macros
// shared forms for the concurrent checks of the deframer
// ----------------------------------------------------------------------------
`ifndef CHUNKED_MESSAGE_DEFRAMER_ASSERT_SVH
`define CHUNKED_MESSAGE_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define CMD_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed");

// next-cycle implication
`define CMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

>>> hw/rtl/cmd_pkg.sv
// ----------------------------------------------------------------------------
// cmd_pkg
// types and constants shared by the chunked message deframer modules
// ----------------------------------------------------------------------------
package cmd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned COUNT_W = 24;
  localparam int unsigned KIND_W  = 2;

  localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

  localparam logic [LEN_W-1:0]   MAX_CHUNK_RESET = 16'hFFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = 24'hFFFFFF;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  out_byte;
    logic [COUNT_W-1:0] message_length;
  } result_t;

endpackage

>>> hw/rtl/cmd_parse.sv
// ----------------------------------------------------------------------------
// cmd_parse
// header/payload tracker: decodes one accepted beat and builds its result
// ----------------------------------------------------------------------------
module cmd_parse (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         beat,
  input  logic [cmd_pkg::BYTE_W-1:0]   in_byte,
  input  logic [cmd_pkg::LEN_W-1:0]    max_chunk_size,
  output logic                         res_valid,
  output cmd_pkg::result_t             res
);

  typedef enum logic [1:0] {
    PH_LEN_HIGH = 2'd0,
    PH_LEN_LOW  = 2'd1,
    PH_PAYLOAD  = 2'd2,
    PH_FAILED   = 2'd3
  } phase_t;

  phase_t                        phase, phase_next;
  logic [cmd_pkg::BYTE_W-1:0]    length_high, length_high_next;
  logic [cmd_pkg::LEN_W-1:0]     chunk_remaining, chunk_remaining_next;
  logic [cmd_pkg::COUNT_W-1:0]   message_count, message_count_next;
  logic [cmd_pkg::LEN_W-1:0]     len;
  logic [cmd_pkg::LEN_W-1:0]     remaining_dec;

  assign len = {length_high, in_byte};
  assign remaining_dec = (chunk_remaining != '0) ? chunk_remaining - 1'b1 : chunk_remaining;

  always_comb begin
    phase_next           = phase;
    length_high_next     = length_high;
    chunk_remaining_next = chunk_remaining;
    message_count_next   = message_count;
    res_valid            = 1'b0;
    res.kind             = cmd_pkg::KIND_BYTE;
    res.out_byte         = '0;
    res.message_length   = '0;
    case (phase)
      PH_LEN_HIGH: begin
        length_high_next = in_byte;
        phase_next       = PH_LEN_LOW;
      end
      PH_LEN_LOW: begin
        if (len == '0) begin
          // zero length chunk closes the message
          res_valid          = 1'b1;
          res.kind           = cmd_pkg::KIND_END;
          res.message_length = message_count;
          message_count_next = '0;
          phase_next         = PH_LEN_HIGH;
        end else if (len > max_chunk_size) begin
          res_valid            = 1'b1;
          res.kind             = cmd_pkg::KIND_ERROR;
          message_count_next   = '0;
          chunk_remaining_next = '0;
          phase_next           = PH_FAILED;
        end else begin
          chunk_remaining_next = len;
          phase_next           = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res_valid    = 1'b1;
        res.kind     = cmd_pkg::KIND_BYTE;
        res.out_byte = in_byte;
        if (message_count != cmd_pkg::COUNT_MAX) begin
          message_count_next = message_count + 1'b1;
        end
        chunk_remaining_next = remaining_dec;
        if (remaining_dec == '0) begin
          phase_next = PH_LEN_HIGH;
        end
      end
      default: begin
        // failed: swallow everything until reset
        phase_next = PH_FAILED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_LEN_HIGH;
      length_high     <= '0;
      chunk_remaining <= '0;
      message_count   <= '0;
    end else if (beat) begin
      phase           <= phase_next;
      length_high     <= length_high_next;
      chunk_remaining <= chunk_remaining_next;
      message_count   <= message_count_next;
    end
  end

endmodule

>>> hw/rtl/cmd_outreg.sv
// ----------------------------------------------------------------------------
// cmd_outreg
// result register: holds one result until the output side takes it
// ----------------------------------------------------------------------------
module cmd_outreg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  cmd_pkg::result_t  res,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output cmd_pkg::result_t  held
);

  // a new result may enter when empty or when the held one leaves this cycle
  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule

>>> hw/rtl/chunked_message_deframer.sv
// ----------------------------------------------------------------------------
// chunked_message_deframer
// splits a byte stream of length-prefixed chunks into payload, end and error
// ----------------------------------------------------------------------------
// Takes one byte per cycle, back to back: a header or payload beat is decoded
// in the cycle it is accepted and its result, if any, appears on the output
// in the next cycle from a single result register. in_ready drops only while
// that register holds a result that the output side is not taking in the
// same cycle, so the sustained rate is one byte per clock whenever out_ready
// stays high. max_chunk_size may be written at any idle time and applies from
// the next length header; after a too-large chunk error the block drops all
// further bytes until reset.
module chunked_message_deframer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cmd_pkg::BYTE_W-1:0]   in_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cmd_pkg::KIND_W-1:0]   kind,
  output logic [cmd_pkg::BYTE_W-1:0]   out_byte,
  output logic [cmd_pkg::COUNT_W-1:0]  message_length,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cmd_pkg::LEN_W-1:0]    max_chunk_size
);

`include "chunked_message_deframer_assert.svh"

  logic [cmd_pkg::LEN_W-1:0] max_chunk;
  logic                      beat;
  logic                      res_valid;
  logic                      can_load;
  cmd_pkg::result_t          res;
  cmd_pkg::result_t          held;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chunk <= cmd_pkg::MAX_CHUNK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_chunk <= max_chunk_size;
    end
  end

  assign in_ready = can_load;
  assign beat     = in_valid && in_ready;

  cmd_parse u_parse (
    .clk            (clk),
    .rst            (rst),
    .beat           (beat),
    .in_byte        (in_byte),
    .max_chunk_size (max_chunk),
    .res_valid      (res_valid),
    .res            (res)
  );

  cmd_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .load      (beat && res_valid),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .held      (held)
  );

  assign kind           = held.kind;
  assign out_byte       = held.out_byte;
  assign message_length = held.message_length;

  // once an error leaves, nothing else ever follows it
  `CMD_ASSERT_NEXT(a_error_is_last, clk, rst, out_valid && out_ready && kind == cmd_pkg::KIND_ERROR, !out_valid)
  `CMD_ASSERT_SAME(a_byte_no_length, clk, rst, out_valid && kind == cmd_pkg::KIND_BYTE, message_length == '0)
  `CMD_ASSERT_SAME(a_ctrl_no_byte, clk, rst, out_valid && kind != cmd_pkg::KIND_BYTE, out_byte == '0)

endmodule
